[hdl/matrix_multiply_defines.svh]
// ----------------------------------------------------------------------------
// matrix_multiply_defines.svh
// assertion macros shared by the matrix multiply checkers
// ----------------------------------------------------------------------------
`ifndef MATRIX_MULTIPLY_DEFINES_SVH
`define MATRIX_MULTIPLY_DEFINES_SVH

// same-cycle implication, sampled on clk, off while in reset
`define MM_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define MM_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

[hdl/mm_pkg.sv]
// ----------------------------------------------------------------------------
// mm_pkg
// shared constants, types and helpers of the matrix multiply block
// ----------------------------------------------------------------------------
package mm_pkg;

	// default sizing
	localparam int MM_MAX_DIM   = 8;
	localparam int MM_ELEM_BITS = 16;

	// fixed field widths
	localparam int PROD_W     = 35;
	localparam int CFG_W      = 4;
	localparam int CFG_IDX_W  = 2;
	localparam int OUT_IDX_W  = 3;
	localparam int M_TDATA_W  = 48;

	// register indexes of the configuration port
	localparam logic [CFG_IDX_W-1:0] REG_A_ROWS    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_INNER_DIM = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_B_COLS    = 2'd2;

	// sequencer states
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_START,
		ST_FEED,
		ST_SETTLE,
		ST_MAC,
		ST_EMIT
	} mm_state_t;

	// control broadcast to the cell chain
	typedef struct packed {
		logic clr;
		logic b_shift;
		logic mac;
		logic acc_shift;
	} mm_ctrl_t;

	// zero acts as one, anything above the maximum acts as the maximum
	function automatic logic [4:0] eff_dim(input logic [CFG_W-1:0] v,
		input logic [4:0] max_dim);
		logic [4:0] v5;
		v5 = {1'b0, v};
		if (v5 == 5'd0)
			return 5'd1;
		else if (v5 > max_dim)
			return max_dim;
		else
			return v5;
	endfunction

endpackage

[hdl/matrix_multiply.sv]
// Loading: one element request per cycle, s_tready is high while the block collects A and B.
// Compute: after the completing request the accumulators clear; for each row and term the b row shifts into
// the cell chain, the store read settles and one MAC per term follows; then the results of the row are emitted.
// Results of one row leave one per cycle while m_tready stays high; a new load starts as the last is queued.
// arst_n clears state, counters and the output valid; registers return to one, stores keep data.
// ----------------------------------------------------------------------------
// matrix_multiply
// streaming matrix product on a row of multiply-accumulate cells
// ----------------------------------------------------------------------------
module matrix_multiply #(
	parameter int MAX_DIM   = mm_pkg::MM_MAX_DIM,
	parameter int ELEM_BITS = mm_pkg::MM_ELEM_BITS
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// element
	input  logic [((ELEM_BITS+7)/8)*8-1:0]    s_tdata,
	// req_type
	input  logic                              s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// out_row, out_col, product_value, zero fill
	output logic [mm_pkg::M_TDATA_W-1:0]      m_tdata,
	output logic                              m_tlast,
	input  logic                              cfg_we,
	input  logic [mm_pkg::CFG_IDX_W-1:0]      cfg_index,
	input  logic [mm_pkg::CFG_W-1:0]          cfg_data
);

	localparam int DIM_W  = $clog2(MAX_DIM + 1);
	localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;
	localparam int DEPTH  = MAX_DIM * MAX_DIM;
	localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int MUL_W  = 2 * DIM_W;
	localparam int PW     = mm_pkg::PROD_W;
	localparam int OIW    = mm_pkg::OUT_IDX_W;
	localparam int PAD_W  = mm_pkg::M_TDATA_W - PW - 2 * OIW;

	// configuration
	logic [mm_pkg::CFG_W-1:0] a_rows_q, inner_dim_q, b_cols_q;
	logic [DIM_W-1:0]         r_eff, k_eff, c_eff;
	logic [CNT_W-1:0]         a_size, b_size;

	// load side
	logic                     s_fire, a_wr, b_wr, done;
	logic [CNT_W-1:0]         a_count_q, b_count_q, a_cnt_nxt, b_cnt_nxt;
	logic [ELEM_BITS-1:0]     elem;

	// sequencer
	mm_pkg::mm_state_t        state_q, state_nxt;
	logic [IDX_W-1:0]         row_q, step_q, col_q;
	logic                     row_last, step_last, col_last;
	logic                     start, rd_en, mac, emit;
	logic                     b_shift_s1;
	logic [MUL_W-1:0]         a_addr_w, b_addr_w;
	logic [ELEM_BITS-1:0]     a_rd, b_rd;
	mm_pkg::mm_ctrl_t         ctrl;
	logic signed [PW-1:0]     acc_head;

	// output register
	logic                     m_tvalid_q, m_tlast_q;
	logic [mm_pkg::M_TDATA_W-1:0] m_tdata_q;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_rows_q    <= mm_pkg::CFG_W'(1);
			inner_dim_q <= mm_pkg::CFG_W'(1);
			b_cols_q    <= mm_pkg::CFG_W'(1);
		end else if (cfg_we) begin
			unique case (cfg_index)
				mm_pkg::REG_A_ROWS:    a_rows_q    <= cfg_data;
				mm_pkg::REG_INNER_DIM: inner_dim_q <= cfg_data;
				mm_pkg::REG_B_COLS:    b_cols_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// effective dimensions and matrix sizes
	assign r_eff  = DIM_W'(mm_pkg::eff_dim(a_rows_q, 5'(MAX_DIM)));
	assign k_eff  = DIM_W'(mm_pkg::eff_dim(inner_dim_q, 5'(MAX_DIM)));
	assign c_eff  = DIM_W'(mm_pkg::eff_dim(b_cols_q, 5'(MAX_DIM)));
	assign a_size = CNT_W'(MUL_W'(r_eff) * MUL_W'(k_eff));
	assign b_size = CNT_W'(MUL_W'(k_eff) * MUL_W'(c_eff));

	// request intake, surplus elements are dropped
	assign s_fire    = s_tvalid && s_tready;
	assign elem      = s_tdata[ELEM_BITS-1:0];
	assign a_wr      = s_fire && !s_tuser && (a_count_q < a_size);
	assign b_wr      = s_fire && s_tuser && (b_count_q < b_size);
	assign a_cnt_nxt = a_wr ? a_count_q + CNT_W'(1) : a_count_q;
	assign b_cnt_nxt = b_wr ? b_count_q + CNT_W'(1) : b_count_q;
	assign done      = s_fire && (a_cnt_nxt >= a_size) && (b_cnt_nxt >= b_size);

	// element counters, cleared when both matrices are complete
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			a_count_q <= '0;
			b_count_q <= '0;
		end else if (done) begin
			a_count_q <= '0;
			b_count_q <= '0;
		end else begin
			a_count_q <= a_cnt_nxt;
			b_count_q <= b_cnt_nxt;
		end
	end

	// loop position flags
	assign row_last  = (DIM_W'(row_q) == r_eff - DIM_W'(1));
	assign step_last = (DIM_W'(step_q) == k_eff - DIM_W'(1));
	assign col_last  = (DIM_W'(col_q) == c_eff - DIM_W'(1));

	// a[row][step], and b[step][c-1-col] so that cell zero ends with column zero
	assign a_addr_w = MUL_W'(row_q) * MUL_W'(k_eff) + MUL_W'(step_q);
	assign b_addr_w = MUL_W'(step_q) * MUL_W'(c_eff) + MUL_W'(c_eff)
		- MUL_W'(1) - MUL_W'(col_q);

	mm_store #(
		.WIDTH (ELEM_BITS),
		.DEPTH (DEPTH),
		.ADDR_W(ADDR_W)
	) u_a_store (
		.clk  (clk),
		.we   (a_wr),
		.waddr(ADDR_W'(a_count_q)),
		.wdata(elem),
		.re   (rd_en),
		.raddr(ADDR_W'(a_addr_w)),
		.rdata(a_rd)
	);

	mm_store #(
		.WIDTH (ELEM_BITS),
		.DEPTH (DEPTH),
		.ADDR_W(ADDR_W)
	) u_b_store (
		.clk  (clk),
		.we   (b_wr),
		.waddr(ADDR_W'(b_count_q)),
		.wdata(elem),
		.re   (rd_en),
		.raddr(ADDR_W'(b_addr_w)),
		.rdata(b_rd)
	);

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= mm_pkg::ST_LOAD;
		else
			state_q <= state_nxt;
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			mm_pkg::ST_LOAD:   if (done) state_nxt = mm_pkg::ST_START;
			mm_pkg::ST_START:  state_nxt = mm_pkg::ST_FEED;
			mm_pkg::ST_FEED:   if (col_last) state_nxt = mm_pkg::ST_SETTLE;
			mm_pkg::ST_SETTLE: state_nxt = mm_pkg::ST_MAC;
			mm_pkg::ST_MAC:    state_nxt = step_last ? mm_pkg::ST_EMIT : mm_pkg::ST_FEED;
			mm_pkg::ST_EMIT: begin
				if (emit && col_last)
					state_nxt = row_last ? mm_pkg::ST_LOAD : mm_pkg::ST_FEED;
			end
			default: state_nxt = mm_pkg::ST_LOAD;
		endcase
	end

	// state outputs
	always_comb begin
		s_tready = 1'b0;
		start    = 1'b0;
		rd_en    = 1'b0;
		mac      = 1'b0;
		emit     = 1'b0;
		unique case (state_q)
			mm_pkg::ST_LOAD:   s_tready = 1'b1;
			mm_pkg::ST_START:  start = 1'b1;
			mm_pkg::ST_FEED:   rd_en = 1'b1;
			mm_pkg::ST_SETTLE: ;
			mm_pkg::ST_MAC:    mac = 1'b1;
			mm_pkg::ST_EMIT:   emit = !m_tvalid_q || m_tready;
			default: ;
		endcase
	end

	// row, term and column counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q  <= '0;
			step_q <= '0;
			col_q  <= '0;
		end else begin
			unique case (state_q)
				mm_pkg::ST_START: begin
					row_q  <= '0;
					step_q <= '0;
					col_q  <= '0;
				end
				mm_pkg::ST_FEED: begin
					if (col_last)
						col_q <= '0;
					else
						col_q <= col_q + IDX_W'(1);
				end
				mm_pkg::ST_MAC: begin
					if (step_last)
						step_q <= '0;
					else
						step_q <= step_q + IDX_W'(1);
				end
				mm_pkg::ST_EMIT: begin
					if (emit) begin
						if (col_last) begin
							col_q <= '0;
							if (row_last)
								row_q <= '0;
							else
								row_q <= row_q + IDX_W'(1);
						end else begin
							col_q <= col_q + IDX_W'(1);
						end
					end
				end
				default: ;
			endcase
		end
	end

	// b shift is the read enable registered, so it follows the read in the next cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			b_shift_s1 <= 1'b0;
		else
			b_shift_s1 <= rd_en;
	end

	// chain control
	always_comb begin
		ctrl.clr       = start;
		ctrl.b_shift   = b_shift_s1;
		ctrl.mac       = mac;
		ctrl.acc_shift = emit;
	end

	mm_chain #(
		.MAX_DIM  (MAX_DIM),
		.ELEM_BITS(ELEM_BITS),
		.DIM_W    (DIM_W)
	) u_chain (
		.clk     (clk),
		.ctrl    (ctrl),
		.c_eff   (c_eff),
		.a_val   ($signed(a_rd)),
		.b_feed  ($signed(b_rd)),
		.acc_head(acc_head)
	);

	// output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			m_tvalid_q <= 1'b0;
		else if (emit)
			m_tvalid_q <= 1'b1;
		else if (m_tready)
			m_tvalid_q <= 1'b0;
	end

	// output payload
	always_ff @(posedge clk) begin
		if (emit) begin
			m_tdata_q <= {{PAD_W{1'b0}}, acc_head, OIW'(col_q), OIW'(row_q)};
			m_tlast_q <= row_last && col_last;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = m_tdata_q;
	assign m_tlast  = m_tlast_q;

endmodule

[hdl/mm_store.sv]
// ----------------------------------------------------------------------------
// mm_store
// element store, one write port and one registered read port
// ----------------------------------------------------------------------------
module mm_store #(
	parameter int WIDTH  = mm_pkg::MM_ELEM_BITS,
	parameter int DEPTH  = mm_pkg::MM_MAX_DIM * mm_pkg::MM_MAX_DIM,
	parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic              clk,
	input  logic              we,
	input  logic [ADDR_W-1:0] waddr,
	input  logic [WIDTH-1:0]  wdata,
	input  logic              re,
	input  logic [ADDR_W-1:0] raddr,
	output logic [WIDTH-1:0]  rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
	end

	// read port, data held until the next read
	always_ff @(posedge clk) begin
		if (re)
			rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

[hdl/mm_cell.sv]
// ----------------------------------------------------------------------------
// mm_cell
// one column of the product row: holds a b element and an accumulator
// ----------------------------------------------------------------------------
module mm_cell #(
	parameter int ELEM_BITS = mm_pkg::MM_ELEM_BITS
) (
	input  logic                              clk,
	input  mm_pkg::mm_ctrl_t                  ctrl,
	input  logic                              mac_sel,
	input  logic signed [ELEM_BITS-1:0]       a_val,
	input  logic signed [ELEM_BITS-1:0]       b_in,
	output logic signed [ELEM_BITS-1:0]       b_out,
	input  logic signed [mm_pkg::PROD_W-1:0]  acc_in,
	output logic signed [mm_pkg::PROD_W-1:0]  acc_out
);

	localparam int PW = mm_pkg::PROD_W;

	logic signed [ELEM_BITS-1:0]   b_q;
	logic signed [PW-1:0]          acc_q;
	logic signed [2*ELEM_BITS-1:0] prod;

	// one signed product per cell
	assign prod = a_val * b_q;

	// b elements move up the chain from cell zero
	always_ff @(posedge clk) begin
		if (ctrl.b_shift)
			b_q <= b_in;
	end

	// clear, accumulate, or move sums down toward the output end
	always_ff @(posedge clk) begin
		if (ctrl.clr)
			acc_q <= '0;
		else if (ctrl.mac && mac_sel)
			acc_q <= acc_q + PW'(prod);
		else if (ctrl.acc_shift)
			acc_q <= acc_in;
	end

	assign b_out   = b_q;
	assign acc_out = acc_q;

endmodule

[hdl/mm_chain.sv]
// ----------------------------------------------------------------------------
// mm_chain
// row of multiply-accumulate cells, one for each product column
// ----------------------------------------------------------------------------
module mm_chain #(
	parameter int MAX_DIM   = mm_pkg::MM_MAX_DIM,
	parameter int ELEM_BITS = mm_pkg::MM_ELEM_BITS,
	parameter int DIM_W     = $clog2(MAX_DIM + 1)
) (
	input  logic                              clk,
	input  mm_pkg::mm_ctrl_t                  ctrl,
	input  logic [DIM_W-1:0]                  c_eff,
	input  logic signed [ELEM_BITS-1:0]       a_val,
	input  logic signed [ELEM_BITS-1:0]       b_feed,
	output logic signed [mm_pkg::PROD_W-1:0]  acc_head
);

	localparam int PW = mm_pkg::PROD_W;

	logic signed [ELEM_BITS-1:0] b_w   [MAX_DIM];
	logic signed [PW-1:0]        acc_w [MAX_DIM];

	// b enters at cell zero, sums leave at cell zero, zeros enter at the top
	for (genvar j = 0; j < MAX_DIM; j++) begin : g_cell
		logic signed [ELEM_BITS-1:0] b_in;
		logic signed [PW-1:0]        acc_in;
		logic                        mac_sel;

		if (j == 0) begin : g_first
			assign b_in = b_feed;
		end else begin : g_next
			assign b_in = b_w[j-1];
		end

		if (j == MAX_DIM - 1) begin : g_top
			assign acc_in = '0;
		end else begin : g_mid
			assign acc_in = acc_w[j+1];
		end

		// only the configured columns accumulate, the rest stay at zero
		assign mac_sel = (DIM_W'(j) < c_eff);

		mm_cell #(
			.ELEM_BITS(ELEM_BITS)
		) u_cell (
			.clk    (clk),
			.ctrl   (ctrl),
			.mac_sel(mac_sel),
			.a_val  (a_val),
			.b_in   (b_in),
			.b_out  (b_w[j]),
			.acc_in (acc_in),
			.acc_out(acc_w[j])
		);
	end

	assign acc_head = acc_w[0];

endmodule

[hdl/mm_checker.sv]
// ----------------------------------------------------------------------------
// mm_checker
// port-level checks of the matrix multiply block
// ----------------------------------------------------------------------------
`include "matrix_multiply_defines.svh"

module mm_checker (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          s_tvalid,
	input logic                          s_tready,
	input logic                          m_tvalid,
	input logic                          m_tready,
	input logic [mm_pkg::M_TDATA_W-1:0]  m_tdata,
	input logic                          m_tlast
);

	// a stalled result holds
	`MM_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata) && $stable(m_tlast), "stalled result changed")

	// a fresh result is only queued while intake is closed
	`MM_ASSERT_IMP(a_new_out_busy, m_tvalid && (!$past(m_tvalid) || $past(m_tready)), !$past(s_tready), "result queued during loading")

	// intake closes only on an accepted request
	`MM_ASSERT_IMP(a_close_on_req, $fell(s_tready), $past(s_tvalid && s_tready), "intake closed without a request")

	// intake reopens together with the last result of the product
	`MM_ASSERT_IMP(a_open_on_last, $rose(s_tready), m_tvalid && m_tlast, "intake reopened before the last result")

endmodule

bind matrix_multiply mm_checker u_mm_checker (.*);

[tb/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the streaming matrix multiply: element requests go
// in on the slave stream, and each product element coming back is compared
// with a software predictor that keeps its own copy of the stores and sizes
// ----------------------------------------------------------------------------
module tb_top;

	localparam int CLK_PERIOD    = 12;
	localparam int DIM_LIMIT     = mm_pkg::MM_MAX_DIM;
	localparam int ELEM_W        = mm_pkg::MM_ELEM_BITS;
	localparam int SETTLE_CYCLES = 720;
	localparam int ITEM_TARGET   = 450;
	localparam int LATE_PART     = 380;
	localparam longint LIMIT_NS  = 64'd60_000_000;

	// one product element as the block reports it
	typedef struct packed {
		logic [mm_pkg::OUT_IDX_W-1:0] row;
		logic [mm_pkg::OUT_IDX_W-1:0] col;
		logic [mm_pkg::PROD_W-1:0]    value;
		logic                         last;
	} product_t;

	logic                         clk = 1'b0;
	logic                         arst_n;
	logic                         s_tvalid;
	logic                         s_tready;
	logic [ELEM_W-1:0]            s_tdata;
	logic                         s_tuser;
	logic                         m_tvalid;
	logic                         m_tready = 1'b0;
	logic [mm_pkg::M_TDATA_W-1:0] m_tdata;
	logic                         m_tlast;
	logic                         cfg_we;
	logic [mm_pkg::CFG_IDX_W-1:0] cfg_index;
	logic [mm_pkg::CFG_W-1:0]     cfg_data;

	// predictor state: stores, fill counters and register shadows
	logic signed [ELEM_W-1:0] a_mem [DIM_LIMIT*DIM_LIMIT];
	logic signed [ELEM_W-1:0] b_mem [DIM_LIMIT*DIM_LIMIT];
	int unsigned              a_fill = 0;
	int unsigned              b_fill = 0;
	logic [mm_pkg::CFG_W-1:0] rows_reg  = 1;
	logic [mm_pkg::CFG_W-1:0] inner_reg = 1;
	logic [mm_pkg::CFG_W-1:0] cols_reg  = 1;
	product_t                 product_q [$];

	// run bookkeeping
	int  err_cnt     = 0;
	int  checked_cnt = 0;
	int  run_cnt     = 0;
	int  loaded_cnt  = 0;
	int  ignored_cnt = 0;
	int  reshape_cnt = 0;
	int  sink_hold   = 0;
	bit  src_idle    = 1'b1;
	bit  sink_idle   = 1'b1;

	matrix_multiply dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),   // element
		.s_tuser   (s_tuser),   // req_type
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),   // out_row, out_col, product_value, zero fill
		.m_tlast   (m_tlast),   // last_of_run
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// clock
	always #(CLK_PERIOD/2) clk = ~clk;

	// zero acts as one, above the maximum acts as the maximum
	function automatic int unsigned clamp_dim(input logic [mm_pkg::CFG_W-1:0] v);
		if (v == 0)
			return 1;
		if (v > DIM_LIMIT)
			return DIM_LIMIT;
		return v;
	endfunction

	// element value, biased toward the extremes
	function automatic logic [ELEM_W-1:0] rand_elem();
		case ($urandom_range(0, 7))
			0: return 16'h8000;
			1: return 16'h7fff;
			2: return 16'h0000;
			3: return 16'hffff;
			default: return ELEM_W'($urandom);
		endcase
	endfunction

	// register value, with the clamped extremes now and then
	function automatic logic [mm_pkg::CFG_W-1:0] rand_dim();
		case ($urandom_range(0, 9))
			0: return 4'd0;
			1: return 4'd15;
			2: return 4'd8;
			default: return mm_pkg::CFG_W'($urandom_range(1, 3));
		endcase
	endfunction

	task automatic report_error(input string msg);
		$display("ERROR at %0t ns: %s", $time, msg);
		err_cnt++;
	endtask

	// store one accepted element and, once both matrices are full, queue the product
	task automatic accept_element(input logic is_b, input logic [ELEM_W-1:0] val);
		int unsigned r, k, c, i, j, m;
		longint      acc;
		product_t    p;
		r = clamp_dim(rows_reg);
		k = clamp_dim(inner_reg);
		c = clamp_dim(cols_reg);
		if (!is_b) begin
			if (a_fill < r * k) begin
				a_mem[a_fill] = val;
				a_fill++;
				loaded_cnt++;
			end else begin
				ignored_cnt++;
			end
		end else begin
			if (b_fill < k * c) begin
				b_mem[b_fill] = val;
				b_fill++;
				loaded_cnt++;
			end else begin
				ignored_cnt++;
			end
		end
		if (a_fill >= r * k && b_fill >= k * c) begin
			for (i = 0; i < r; i++) begin
				for (j = 0; j < c; j++) begin
					acc = 0;
					for (m = 0; m < k; m++)
						acc += longint'(a_mem[i*k + m]) * longint'(b_mem[m*c + j]);
					p.row   = mm_pkg::OUT_IDX_W'(i);
					p.col   = mm_pkg::OUT_IDX_W'(j);
					p.value = acc[mm_pkg::PROD_W-1:0];
					p.last  = (i == r - 1) && (j == c - 1);
					product_q = {product_q, p};
				end
			end
			a_fill = 0;
			b_fill = 0;
			run_cnt++;
		end
	endtask

	// one element request, with an optional idle burst ahead of it
	task automatic push_element(input logic is_b, input logic [ELEM_W-1:0] val);
		int gap;
		if (src_idle && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 9);
			@(negedge clk);
			s_tvalid <= 1'b0;
			repeat (gap - 1) @(negedge clk);
		end
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser  <= is_b;
		s_tdata  <= val;
		do @(posedge clk); while (!s_tready);
		accept_element(is_b, val);
	endtask

	// drop the request and hold off until every product element has come back
	task automatic wait_results();
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (product_q.size() != 0)
			@(posedge clk);
	endtask

	task automatic write_reg(input logic [mm_pkg::CFG_IDX_W-1:0] idx,
		input logic [mm_pkg::CFG_W-1:0] val);
		@(negedge clk);
		cfg_we    <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= val;
		case (idx)
			mm_pkg::REG_A_ROWS:    rows_reg  = val;
			mm_pkg::REG_INNER_DIM: inner_reg = val;
			mm_pkg::REG_B_COLS:    cols_reg  = val;
			default: ;
		endcase
	endtask

	// reprogram all three sizes once the block has gone quiet
	task automatic set_dims(input logic [mm_pkg::CFG_W-1:0] r,
		input logic [mm_pkg::CFG_W-1:0] k, input logic [mm_pkg::CFG_W-1:0] c);
		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);
		write_reg(mm_pkg::REG_A_ROWS, r);
		write_reg(mm_pkg::REG_INNER_DIM, k);
		write_reg(mm_pkg::REG_B_COLS, c);
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	// feed elements until one product has been triggered
	task automatic run_matrices(input bit allow_noise);
		int  start_run, a_size, b_size, a_left, b_left;
		bit  pick_b, reshaped;
		start_run = run_cnt;
		reshaped  = 1'b0;
		while (run_cnt == start_run) begin
			a_size = clamp_dim(rows_reg) * clamp_dim(inner_reg);
			b_size = clamp_dim(inner_reg) * clamp_dim(cols_reg);
			a_left = (a_fill < a_size) ? a_size - a_fill : 0;
			b_left = (b_fill < b_size) ? b_size - b_fill : 0;
			// surplus elements go to a matrix that is already full
			if (a_left == 0 && b_left == 0)
				pick_b = $urandom_range(0, 1);
			else if (a_left == 0)
				pick_b = !(allow_noise && $urandom_range(0, 5) == 0);
			else if (b_left == 0)
				pick_b = allow_noise && $urandom_range(0, 5) == 0;
			else
				pick_b = $urandom_range(0, 1);
			push_element(pick_b, rand_elem());
			// resize halfway through a load now and then
			if (allow_noise && !reshaped && run_cnt == start_run &&
				$urandom_range(0, 59) == 0) begin
				reshaped = 1'b1;
				reshape_cnt++;
				set_dims(mm_pkg::CFG_W'($urandom_range(1, 4)),
					mm_pkg::CFG_W'($urandom_range(1, 4)),
					mm_pkg::CFG_W'($urandom_range(1, 4)));
			end
		end
	endtask

	// reset sizes: 1x1 by 1x1 with the extreme elements, either order
	task automatic test_single_elements();
		push_element(1'b0, 16'h8000);
		push_element(1'b1, 16'h8000);
		push_element(1'b1, 16'h7fff);
		push_element(1'b0, 16'h8000);
		wait_results();
	endtask

	// elements beyond a full matrix are dropped
	task automatic test_surplus_elements();
		set_dims(4'd1, 4'd1, 4'd1);
		push_element(1'b0, 16'h0100);
		push_element(1'b0, 16'h7fff);
		push_element(1'b0, 16'h8000);
		push_element(1'b1, 16'h0200);
		wait_results();
	endtask

	// zero in every register acts as one
	task automatic test_zero_dims();
		set_dims(4'd0, 4'd0, 4'd0);
		push_element(1'b1, 16'hffff);
		push_element(1'b0, 16'h7fff);
		wait_results();
	endtask

	// a row count above the maximum acts as the maximum
	task automatic test_clamped_rows();
		int n;
		set_dims(4'd15, 4'd1, 4'd0);
		for (n = 0; n < DIM_LIMIT; n++)
			push_element(1'b0, rand_elem());
		push_element(1'b1, 16'h8000);
		wait_results();
	endtask

	// shrinking the sizes mid-load completes both matrices on the next request
	task automatic test_reconfig_mid_load();
		set_dims(4'd2, 4'd2, 4'd2);
		push_element(1'b0, 16'h0180);
		push_element(1'b0, 16'h8000);
		push_element(1'b0, 16'h7fff);
		push_element(1'b1, 16'hff00);
		push_element(1'b1, 16'h1234);
		set_dims(4'd1, 4'd1, 4'd1);
		reshape_cnt++;
		push_element(1'b0, 16'h5555);
		wait_results();
	endtask

	// random sizes and content, with surplus noise and mid-load resizing
	task automatic test_random_runs();
		int phase_idx, runs_left, run_idx;
		phase_idx = 0;
		runs_left = 0;
		run_idx   = 0;
		while (loaded_cnt < ITEM_TARGET) begin
			if (runs_left == 0) begin
				if (phase_idx % 9 == 3) begin
					set_dims($urandom_range(0, 1) ? 4'd8 : 4'd15,
						$urandom_range(0, 1) ? 4'd8 : 4'd15,
						$urandom_range(0, 1) ? 4'd8 : 4'd15);
					runs_left = 1;
				end else begin
					set_dims(rand_dim(), rand_dim(), rand_dim());
					runs_left = $urandom_range(1, 3);
				end
				phase_idx++;
			end
			// idle stretches, none in the last part
			if (loaded_cnt > LATE_PART) begin
				src_idle  = 1'b0;
				sink_idle = 1'b0;
			end else begin
				src_idle  = $urandom_range(0, 3) != 0;
				sink_idle = $urandom_range(0, 3) != 0;
			end
			run_matrices(1'b1);
			runs_left--;
			run_idx++;
			// sender holds off until the product has fully drained
			if (run_idx % 5 == 4)
				wait_results();
		end
	endtask

	// sink ready with random stall bursts
	always @(negedge clk) begin
		if (sink_hold > 0) begin
			sink_hold <= sink_hold - 1;
			m_tready  <= 1'b0;
		end else if (sink_idle && $urandom_range(0, 5) == 0) begin
			sink_hold <= $urandom_range(0, 8);
			m_tready  <= 1'b0;
		end else begin
			m_tready  <= 1'b1;
		end
	end

	// compare each accepted product element with the oldest one predicted
	always @(posedge clk) begin : result_check
		product_t want;
		if (arst_n && m_tvalid && m_tready) begin
			if (product_q.size() == 0) begin
				report_error("product element with none pending");
			end else begin
				want = product_q.pop_front();
				checked_cnt++;
				if (m_tdata[2:0] !== want.row)
					report_error($sformatf("row %0d, want %0d", m_tdata[2:0], want.row));
				if (m_tdata[5:3] !== want.col)
					report_error($sformatf("col %0d, want %0d", m_tdata[5:3], want.col));
				if (m_tdata[6 +: mm_pkg::PROD_W] !== want.value)
					report_error($sformatf("value %h, want %h at (%0d,%0d)",
						m_tdata[6 +: mm_pkg::PROD_W], want.value, want.row, want.col));
				if (m_tlast !== want.last)
					report_error($sformatf("last %b, want %b at (%0d,%0d)",
						m_tlast, want.last, want.row, want.col));
			end
		end
	end

	// main sequence
	initial begin
		s_tvalid  = 1'b0;
		s_tdata   = '0;
		s_tuser   = 1'b0;
		cfg_we    = 1'b0;
		cfg_index = '0;
		cfg_data  = '0;
		arst_n    = 1'b0;
		repeat (2) @(negedge clk);
		arst_n = 1'b1;

		test_single_elements();
		test_surplus_elements();
		test_zero_dims();
		test_clamped_rows();
		test_reconfig_mid_load();
		test_random_runs();

		wait_results();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("covered %0d products, %0d elements checked, %0d elements loaded, %0d dropped",
			run_cnt, checked_cnt, loaded_cnt, ignored_cnt);
		$display("sizes from 0 to 15 per register, %0d mid-load resizes, %0d mismatches",
			reshape_cnt, err_cnt);
		if (err_cnt == 0)
			$display("simulation ok");
		else
			$display("simulation failed");
		$finish;
	end

	// watchdog
	initial begin
		#(LIMIT_NS);
		$display("simulation failed");
		$finish;
	end

endmodule
